// ===== design/rre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rre_pkg;

  localparam int unsigned PackedDeltaBitsDef = 28;
  localparam int unsigned MaxEntries = 14;
  localparam int unsigned StepW = $clog2(MaxEntries);
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CodeNone = 8'd0;
  localparam logic [7:0] CodeAbs32 = 8'd2;
  localparam logic [7:0] CodeMovw = 8'd43;
  localparam logic [7:0] CodeMovt = 8'd44;
  localparam logic [7:0] CodeThmMovw = 8'd47;
  localparam logic [7:0] CodeThmMovt = 8'd48;

  typedef enum logic [3:0] {
    ActAbs      = 4'd0,
    ActAbsSplit = 4'd1,
    ActRel      = 4'd2,
    ActMov      = 4'd3,
    ActPair     = 4'd4,
    ActQuad     = 4'd5,
    ActAbs32    = 4'd6,
    ActPack7    = 4'd7,
    ActPack4    = 4'd8,
    ActPack2    = 4'd9
  } act_e;

  typedef enum logic [1:0] {
    StEntry     = 2'd0,
    StBadFirst  = 2'd1,
    StZeroDelta = 2'd2,
    StUnknown   = 2'd3
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [3:0]  action;
    logic [3:0]  seg_target;
    logic [3:0]  seg_symbol;
    logic [7:0]  code_one;
    logic [7:0]  code_two;
    logic        is_thumb;
    logic [31:0] target_offset;
    logic [19:0] target_offset_two;
    logic [31:0] symbol_offset;
    logic [11:0] append_offset_one;
    logic [11:0] append_offset_two;
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/relocation_record_expander_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Relocation record expander. Each accepted input beat is one unpacked compact
// relocation record; it yields one to fourteen ARM relocation entries, or a
// single status beat for a failed list, or nothing while a failed list is being
// skipped. The last beat of a record carries last_o. The back end emits one
// entry per cycle, unless out_ready_i stalls it, from a running-value
// sequencer; a record holds it until its last beat (fourteen at most), and a
// two-deep command queue lets the input side keep accepting records meanwhile.
// Register owner_segment sits at byte address 0 and is copied into every entry.
module relocation_record_expander_unit
  import rre_pkg::*;
#(
  parameter int unsigned PackedDeltaBits = PackedDeltaBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        start_of_list_i,
  input  wire logic [3:0]  action_i,
  input  wire logic [3:0]  seg_target_i,
  input  wire logic [3:0]  seg_symbol_i,
  input  wire logic [7:0]  code_one_i,
  input  wire logic [7:0]  code_two_i,
  input  wire logic        is_thumb_i,
  input  wire logic [31:0] target_offset_i,
  input  wire logic [19:0] target_offset_two_i,
  input  wire logic [31:0] symbol_offset_i,
  input  wire logic [11:0] append_offset_one_i,
  input  wire logic [11:0] append_offset_two_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       entry_target_segment_o,
  output logic [31:0]      entry_target_offset_o,
  output logic [3:0]       entry_symbol_segment_o,
  output logic [31:0]      entry_symbol_offset_o,
  output logic [7:0]       entry_code_o,
  output logic [3:0]       entry_owner_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  logic [3:0] owner_q;
  logic       push, pop, full, head_valid;
  cmd_t       push_cmd, head_cmd;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {28'd0, owner_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      owner_q <= pwdata[3:0];
    end
  end

  rre_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .start_of_list_i     (start_of_list_i),
    .action_i            (action_i),
    .seg_target_i        (seg_target_i),
    .seg_symbol_i        (seg_symbol_i),
    .code_one_i          (code_one_i),
    .code_two_i          (code_two_i),
    .is_thumb_i          (is_thumb_i),
    .target_offset_i     (target_offset_i),
    .target_offset_two_i (target_offset_two_i),
    .symbol_offset_i     (symbol_offset_i),
    .append_offset_one_i (append_offset_one_i),
    .append_offset_two_i (append_offset_two_i),
    .queue_full_i        (full),
    .push_o              (push),
    .cmd_o               (push_cmd)
  );

  rre_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (head_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  rre_back #(
    .PackedDeltaBits (PackedDeltaBits)
  ) u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_valid_i            (head_valid),
    .cmd_i                  (head_cmd),
    .cmd_pop_o              (pop),
    .owner_i                (owner_q),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .entry_target_segment_o (entry_target_segment_o),
    .entry_target_offset_o  (entry_target_offset_o),
    .entry_symbol_segment_o (entry_symbol_segment_o),
    .entry_symbol_offset_o  (entry_symbol_offset_o),
    .entry_code_o           (entry_code_o),
    .entry_owner_o          (entry_owner_o),
    .status_o               (status_o),
    .last_o                 (last_o)
  );

endmodule
`default_nettype wire

// ===== design/rre_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rre_front
  import rre_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        start_of_list_i,
  input  wire logic [3:0]  action_i,
  input  wire logic [3:0]  seg_target_i,
  input  wire logic [3:0]  seg_symbol_i,
  input  wire logic [7:0]  code_one_i,
  input  wire logic [7:0]  code_two_i,
  input  wire logic        is_thumb_i,
  input  wire logic [31:0] target_offset_i,
  input  wire logic [19:0] target_offset_two_i,
  input  wire logic [31:0] symbol_offset_i,
  input  wire logic [11:0] append_offset_one_i,
  input  wire logic [11:0] append_offset_two_i,
  input  wire logic        queue_full_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic    failed_q, failed_d;
  logic    accept;
  logic    keep;
  status_e status;

  assign in_ready_o = !queue_full_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    failed_d = failed_q;
    keep = 1'b1;
    status = StEntry;
    if (start_of_list_i) begin
      failed_d = 1'b0;
      if (!(action_i inside {ActAbs, ActAbsSplit})) begin
        status = StBadFirst;
        failed_d = 1'b1;
      end
    end else if (failed_q) begin
      keep = 1'b0;
    end else if (action_i == ActAbs32 && target_offset_i == 32'd0) begin
      status = StZeroDelta;
      failed_d = 1'b1;
    end else if (!(action_i inside {[ActAbs:ActPack2]})) begin
      status = StUnknown;
      failed_d = 1'b1;
    end
  end

  always_comb begin
    cmd_o.status            = status;
    cmd_o.action            = action_i;
    cmd_o.seg_target        = seg_target_i;
    cmd_o.seg_symbol        = seg_symbol_i;
    cmd_o.code_one          = code_one_i;
    cmd_o.code_two          = code_two_i;
    cmd_o.is_thumb          = is_thumb_i;
    cmd_o.target_offset     = target_offset_i;
    cmd_o.target_offset_two = target_offset_two_i;
    cmd_o.symbol_offset     = symbol_offset_i;
    cmd_o.append_offset_one = append_offset_one_i;
    cmd_o.append_offset_two = append_offset_two_i;
  end

  assign push_o = accept && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failed_q <= 1'b0;
    end else if (accept) begin
      failed_q <= failed_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/rre_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rre_cmd_fifo
  import rre_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      cmd_o,
  input  wire logic pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/rre_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rre_back
  import rre_pkg::*;
#(
  parameter int unsigned PackedDeltaBits = PackedDeltaBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire cmd_t        cmd_i,
  output logic             cmd_pop_o,
  input  wire logic [3:0]  owner_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       entry_target_segment_o,
  output logic [31:0]      entry_target_offset_o,
  output logic [3:0]       entry_symbol_segment_o,
  output logic [31:0]      entry_symbol_offset_o,
  output logic [7:0]       entry_code_o,
  output logic [3:0]       entry_owner_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  localparam logic [StepW-1:0] LastStep = StepW'(MaxEntries - 1);

  logic [31:0] run_toff_q, run_soff_q;
  logic [7:0]  run_c1_q, run_c2_q;
  logic [3:0]  run_tseg_q, run_sseg_q;
  logic [StepW-1:0] step_q;
  logic [PackedDeltaBits-1:0] rest_q, rest_cur, rest_nxt;

  logic [31:0] nxt_toff, nxt_soff;
  logic [7:0]  nxt_c1, nxt_c2;
  logic [3:0]  nxt_tseg, nxt_sseg;
  logic [31:0] addend, sum, ent_toff;
  logic [7:0]  ent_code;
  logic [6:0]  delta;
  logic        ent_last, is_err, fire;

  logic        out_valid_q;
  logic [3:0]  out_tseg_q, out_sseg_q, out_owner_q;
  logic [31:0] out_toff_q, out_soff_q;
  logic [7:0]  out_code_q;
  logic [1:0]  out_status_q;
  logic        out_last_q;

  assign is_err = cmd_i.status != StEntry;
  assign fire = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = fire && ent_last;
  assign sum = run_toff_q + addend;

  always_comb begin
    rest_cur = (step_q == '0) ? cmd_i.target_offset[PackedDeltaBits-1:0] : rest_q;
    case (cmd_i.action)
      ActPack7: begin
        delta = rest_cur[6:0];
        rest_nxt = rest_cur >> 7;
      end
      ActPack4: begin
        delta = {3'b000, rest_cur[3:0]};
        rest_nxt = rest_cur >> 4;
      end
      default: begin
        delta = {5'b00000, rest_cur[1:0]};
        rest_nxt = rest_cur >> 2;
      end
    endcase
  end

  always_comb begin
    nxt_toff = run_toff_q;
    nxt_soff = run_soff_q;
    nxt_c1   = run_c1_q;
    nxt_c2   = run_c2_q;
    nxt_tseg = run_tseg_q;
    nxt_sseg = run_sseg_q;
    addend   = 32'd0;
    ent_toff = sum;
    ent_code = CodeNone;
    ent_last = 1'b1;
    case (cmd_i.action)
      ActAbs: begin
        if (step_q == '0) begin
          nxt_toff = cmd_i.target_offset;
          nxt_soff = cmd_i.symbol_offset;
          nxt_c1   = cmd_i.code_one;
          nxt_c2   = cmd_i.code_two;
          nxt_tseg = cmd_i.seg_target;
          nxt_sseg = cmd_i.seg_symbol;
          ent_toff = cmd_i.target_offset;
          ent_code = cmd_i.code_one;
          ent_last = 1'b0;
        end else begin
          addend   = {20'd0, cmd_i.append_offset_one};
          ent_code = run_c2_q;
        end
      end
      ActAbsSplit: begin
        nxt_toff = {cmd_i.target_offset_two, cmd_i.target_offset[11:0]};
        nxt_soff = cmd_i.symbol_offset;
        nxt_c1   = cmd_i.code_one;
        nxt_c2   = CodeNone;
        nxt_tseg = cmd_i.seg_target;
        nxt_sseg = cmd_i.seg_symbol;
        ent_toff = {cmd_i.target_offset_two, cmd_i.target_offset[11:0]};
        ent_code = cmd_i.code_one;
      end
      ActRel: begin
        addend   = cmd_i.target_offset;
        nxt_toff = sum;
        nxt_soff = cmd_i.symbol_offset;
        nxt_c1   = cmd_i.code_one;
        nxt_c2   = CodeNone;
        nxt_sseg = cmd_i.seg_symbol;
        ent_code = cmd_i.code_one;
      end
      ActMov: begin
        if (step_q == '0) begin
          addend   = cmd_i.target_offset;
          nxt_toff = sum;
          nxt_soff = cmd_i.symbol_offset;
          nxt_c1   = cmd_i.is_thumb ? CodeThmMovw : CodeMovw;
          nxt_c2   = cmd_i.is_thumb ? CodeThmMovt : CodeMovt;
          nxt_sseg = cmd_i.seg_symbol;
          ent_code = cmd_i.is_thumb ? CodeThmMovw : CodeMovw;
          ent_last = 1'b0;
        end else begin
          addend   = {20'd0, cmd_i.append_offset_one};
          ent_code = run_c2_q;
        end
      end
      ActPair: begin
        if (step_q == '0) begin
          addend   = cmd_i.target_offset;
          nxt_toff = sum;
          ent_code = run_c1_q;
          ent_last = 1'b0;
        end else begin
          addend   = {20'd0, cmd_i.append_offset_one};
          ent_code = run_c2_q;
        end
      end
      ActQuad: begin
        case (step_q[1:0])
          2'd0: begin
            addend   = cmd_i.target_offset;
            nxt_toff = sum;
            ent_code = run_c1_q;
            ent_last = 1'b0;
          end
          2'd1: begin
            addend   = {20'd0, cmd_i.append_offset_one};
            ent_code = run_c2_q;
            ent_last = 1'b0;
          end
          2'd2: begin
            addend   = {12'd0, cmd_i.target_offset_two};
            nxt_toff = sum;
            ent_code = run_c1_q;
            ent_last = 1'b0;
          end
          default: begin
            addend   = {20'd0, cmd_i.append_offset_two};
            ent_code = run_c2_q;
          end
        endcase
      end
      ActAbs32: begin
        addend   = cmd_i.target_offset;
        nxt_toff = sum;
        nxt_c1   = CodeAbs32;
        nxt_c2   = CodeNone;
        ent_code = CodeAbs32;
      end
      ActPack7, ActPack4, ActPack2: begin
        addend   = {23'd0, delta, 2'b00};
        nxt_toff = sum;
        nxt_c1   = CodeAbs32;
        nxt_c2   = CodeNone;
        ent_code = CodeAbs32;
        ent_last = (rest_nxt == '0) || (step_q == LastStep);
      end
      default: begin
        ent_last = 1'b1;
      end
    endcase
    if (is_err) begin
      ent_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_toff_q  <= '0;
      run_soff_q  <= '0;
      run_c1_q    <= '0;
      run_c2_q    <= '0;
      run_tseg_q  <= '0;
      run_sseg_q  <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        step_q <= ent_last ? '0 : step_q + 1'b1;
        if (!is_err) begin
          run_toff_q <= nxt_toff;
          run_soff_q <= nxt_soff;
          run_c1_q   <= nxt_c1;
          run_c2_q   <= nxt_c2;
          run_tseg_q <= nxt_tseg;
          run_sseg_q <= nxt_sseg;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rest_q     <= rest_nxt;
      out_last_q <= ent_last;
      out_status_q <= cmd_i.status;
      if (is_err) begin
        out_tseg_q  <= '0;
        out_toff_q  <= '0;
        out_sseg_q  <= '0;
        out_soff_q  <= '0;
        out_code_q  <= '0;
        out_owner_q <= '0;
      end else begin
        out_tseg_q  <= nxt_tseg;
        out_toff_q  <= ent_toff;
        out_sseg_q  <= nxt_sseg;
        out_soff_q  <= nxt_soff;
        out_code_q  <= ent_code;
        out_owner_q <= owner_i;
      end
    end
  end

  assign out_valid_o            = out_valid_q;
  assign entry_target_segment_o = out_tseg_q;
  assign entry_target_offset_o  = out_toff_q;
  assign entry_symbol_segment_o = out_sseg_q;
  assign entry_symbol_offset_o  = out_soff_q;
  assign entry_code_o           = out_code_q;
  assign entry_owner_o          = out_owner_q;
  assign status_o               = out_status_q;
  assign last_o                 = out_last_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LastStep)
    else $error("entry step beyond limit");

  a_step_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0 |-> cmd_valid_i)
    else $error("mid-record step without a command");

  a_pop_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> fire && cmd_valid_i)
    else $error("command popped without a beat");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != StEntry |-> out_last_q && out_code_q == CodeNone)
    else $error("status beat not final or not cleared");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rre_pkg::*;

  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned SettleCycles = 60;
  localparam logic [2:0] RegOwnerSegment = 3'd0;
  localparam logic [3:0] ActUnknownLo = 4'(ActPack2) + 4'd1;
  localparam logic [3:0] ActUnknownHi = 4'hF;
  localparam logic [31:0] PackedMask = 32'((64'd1 << PackedDeltaBitsDef) - 64'd1);

  typedef struct packed {
    logic        start;
    logic [3:0]  action;
    logic [3:0]  seg_target;
    logic [3:0]  seg_symbol;
    logic [7:0]  code_one;
    logic [7:0]  code_two;
    logic        is_thumb;
    logic [31:0] target_offset;
    logic [19:0] target_offset_two;
    logic [31:0] symbol_offset;
    logic [11:0] append_one;
    logic [11:0] append_two;
  } record_t;

  typedef struct packed {
    logic [3:0]  target_segment;
    logic [31:0] target_offset;
    logic [3:0]  symbol_segment;
    logic [31:0] symbol_offset;
    logic [7:0]  code;
    logic [3:0]  owner;
    status_e     status;
    logic        last;
  } entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  logic        in_valid = 1'b0;
  wire         in_ready;
  logic        start_of_list = 1'b0;
  logic [3:0]  action = '0;
  logic [3:0]  seg_target = '0;
  logic [3:0]  seg_symbol = '0;
  logic [7:0]  code_one = '0;
  logic [7:0]  code_two = '0;
  logic        is_thumb = 1'b0;
  logic [31:0] target_offset = '0;
  logic [19:0] target_offset_two = '0;
  logic [31:0] symbol_offset = '0;
  logic [11:0] append_offset_one = '0;
  logic [11:0] append_offset_two = '0;

  wire         out_valid;
  logic        out_ready = 1'b0;
  wire  [3:0]  entry_target_segment;
  wire  [31:0] entry_target_offset;
  wire  [3:0]  entry_symbol_segment;
  wire  [31:0] entry_symbol_offset;
  wire  [7:0]  entry_code;
  wire  [3:0]  entry_owner;
  wire  [1:0]  status;
  wire         last;

  relocation_record_expander_unit DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .start_of_list_i        (start_of_list),
    .action_i               (action),
    .seg_target_i           (seg_target),
    .seg_symbol_i           (seg_symbol),
    .code_one_i             (code_one),
    .code_two_i             (code_two),
    .is_thumb_i             (is_thumb),
    .target_offset_i        (target_offset),
    .target_offset_two_i    (target_offset_two),
    .symbol_offset_i        (symbol_offset),
    .append_offset_one_i    (append_offset_one),
    .append_offset_two_i    (append_offset_two),
    .out_valid_o            (out_valid),
    .out_ready_i            (out_ready),
    .entry_target_segment_o (entry_target_segment),
    .entry_target_offset_o  (entry_target_offset),
    .entry_symbol_segment_o (entry_symbol_segment),
    .entry_symbol_offset_o  (entry_symbol_offset),
    .entry_code_o           (entry_code),
    .entry_owner_o          (entry_owner),
    .status_o               (status),
    .last_o                 (last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  record_t     pending_q[$];
  record_t     cur_rec;
  entry_t      batch_q[$];
  entry_t      expected_entries[$];
  bit          idle_on = 1'b1;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;

  logic [31:0] cur_target_off = '0;
  logic [31:0] cur_symbol_off = '0;
  logic [7:0]  cur_code_a = '0;
  logic [7:0]  cur_code_b = '0;
  logic [3:0]  cur_target_seg = '0;
  logic [3:0]  cur_symbol_seg = '0;
  logic        list_broken = 1'b0;
  logic [3:0]  owner_shadow = '0;

  task automatic emit_entry(input logic [31:0] off, input logic [7:0] code);
    entry_t e;
    e.target_segment = cur_target_seg;
    e.target_offset  = off;
    e.symbol_segment = cur_symbol_seg;
    e.symbol_offset  = cur_symbol_off;
    e.code           = code;
    e.owner          = owner_shadow;
    e.status         = StEntry;
    e.last           = 1'b0;
    batch_q.push_back(e);
  endtask

  task automatic emit_status(input status_e st);
    entry_t e;
    e = '0;
    e.status = st;
    e.last = 1'b1;
    expected_entries.push_back(e);
    list_broken = 1'b1;
  endtask

  task automatic expand_record(input record_t r);
    logic [31:0] rest;
    logic [31:0] mask;
    int unsigned shift;
    entry_t e;
    batch_q.delete();
    if (r.start) begin
      list_broken = 1'b0;
      cur_target_off = '0;
      cur_symbol_off = '0;
      cur_code_a = '0;
      cur_code_b = '0;
      cur_target_seg = '0;
      cur_symbol_seg = '0;
    end
    if (r.start && r.action >= ActRel) begin
      emit_status(StBadFirst);
    end else if (!list_broken) begin
      case (r.action)
        ActAbs: begin
          cur_target_off = r.target_offset;
          cur_symbol_off = r.symbol_offset;
          cur_code_a = r.code_one;
          cur_code_b = r.code_two;
          cur_target_seg = r.seg_target;
          cur_symbol_seg = r.seg_symbol;
          emit_entry(cur_target_off, cur_code_a);
          emit_entry(cur_target_off + 32'(r.append_one), cur_code_b);
        end
        ActAbsSplit: begin
          cur_target_off = {r.target_offset_two, r.target_offset[11:0]};
          cur_symbol_off = r.symbol_offset;
          cur_code_a = r.code_one;
          cur_code_b = CodeNone;
          cur_target_seg = r.seg_target;
          cur_symbol_seg = r.seg_symbol;
          emit_entry(cur_target_off, cur_code_a);
        end
        ActRel: begin
          cur_target_off = cur_target_off + r.target_offset;
          cur_symbol_off = r.symbol_offset;
          cur_code_a = r.code_one;
          cur_code_b = CodeNone;
          cur_symbol_seg = r.seg_symbol;
          emit_entry(cur_target_off, cur_code_a);
        end
        ActMov: begin
          cur_target_off = cur_target_off + r.target_offset;
          cur_symbol_off = r.symbol_offset;
          cur_code_a = r.is_thumb ? CodeThmMovw : CodeMovw;
          cur_code_b = r.is_thumb ? CodeThmMovt : CodeMovt;
          cur_symbol_seg = r.seg_symbol;
          emit_entry(cur_target_off, cur_code_a);
          emit_entry(cur_target_off + 32'(r.append_one), cur_code_b);
        end
        ActPair: begin
          cur_target_off = cur_target_off + r.target_offset;
          emit_entry(cur_target_off, cur_code_a);
          emit_entry(cur_target_off + 32'(r.append_one), cur_code_b);
        end
        ActQuad: begin
          cur_target_off = cur_target_off + r.target_offset;
          emit_entry(cur_target_off, cur_code_a);
          emit_entry(cur_target_off + 32'(r.append_one), cur_code_b);
          cur_target_off = cur_target_off + 32'(r.target_offset_two);
          emit_entry(cur_target_off, cur_code_a);
          emit_entry(cur_target_off + 32'(r.append_two), cur_code_b);
        end
        ActAbs32: begin
          if (r.target_offset == '0) begin
            emit_status(StZeroDelta);
          end else begin
            cur_target_off = cur_target_off + r.target_offset;
            emit_entry(cur_target_off, CodeAbs32);
            cur_code_a = CodeAbs32;
            cur_code_b = CodeNone;
          end
        end
        ActPack7, ActPack4, ActPack2: begin
          shift = (r.action == ActPack7) ? 7 : (r.action == ActPack4) ? 4 : 2;
          mask = (32'd1 << shift) - 32'd1;
          rest = r.target_offset & PackedMask;
          do begin
            cur_target_off = cur_target_off + ((rest & mask) << 2);
            emit_entry(cur_target_off, CodeAbs32);
            rest = rest >> shift;
          end while (rest != '0 && batch_q.size() < MaxEntries);
          cur_code_a = CodeAbs32;
          cur_code_b = CodeNone;
        end
        default: begin
          emit_status(StUnknown);
        end
      endcase
    end
    for (int i = 0; i < batch_q.size(); i++) begin
      e = batch_q[i];
      e.last = (i == batch_q.size() - 1);
      expected_entries.push_back(e);
    end
  endtask

  function automatic record_t rand_record(input logic start, input logic [3:0] act);
    record_t r;
    r.start = start;
    r.action = act;
    r.seg_target = 4'($urandom);
    r.seg_symbol = 4'($urandom);
    r.code_one = 8'($urandom);
    r.code_two = 8'($urandom);
    r.is_thumb = 1'($urandom);
    r.target_offset = $urandom;
    if ($urandom_range(0, 1) == 0) r.target_offset = r.target_offset >> $urandom_range(4, 31);
    r.target_offset_two = 20'($urandom);
    r.symbol_offset = $urandom;
    r.append_one = 12'($urandom);
    r.append_two = 12'($urandom);
    return r;
  endfunction

  task automatic load_lists(input int unsigned quota);
    record_t r;
    int unsigned made;
    int unsigned n;
    int unsigned pick;
    made = 0;
    while (made < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        pending_q.push_back(rand_record(1'b1, 4'($urandom_range(ActAbs, ActAbsSplit))));
        n = $urandom_range(0, 7);
        repeat (n) begin
          r = rand_record(1'b0, 4'($urandom_range(ActAbs, ActPack2)));
          if (r.action == ActAbs32 && r.target_offset == '0) r.target_offset = 32'd4;
          pending_q.push_back(r);
        end
        made += n + 1;
      end else if (pick < 92) begin
        if (pick < 84) begin
          r = rand_record(1'b1, 4'($urandom_range(ActRel, ActUnknownHi)));
        end else begin
          pending_q.push_back(rand_record(1'b1, 4'($urandom_range(ActAbs, ActAbsSplit))));
          made++;
          if (pick < 88) begin
            r = rand_record(1'b0, ActAbs32);
            r.target_offset = '0;
          end else begin
            r = rand_record(1'b0, 4'($urandom_range(ActUnknownLo, ActUnknownHi)));
          end
        end
        pending_q.push_back(r);
        made++;
        n = $urandom_range(0, 2);
        repeat (n) pending_q.push_back(rand_record(1'b0, 4'($urandom)));
        made += n;
      end else begin
        pending_q.push_back(rand_record(1'($urandom), 4'($urandom)));
        made++;
      end
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    owner_shadow = data[3:0];
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || expected_entries.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_beat();
    entry_t want;
    if (expected_entries.size() == 0) begin
      $display("%0t unexpected beat: expected none actual status %0d target %h",
               $time, status, entry_target_offset);
      mismatches++;
    end else begin
      want = expected_entries.pop_front();
      check_field("entry_target_segment", 32'(want.target_segment), 32'(entry_target_segment));
      check_field("entry_target_offset", want.target_offset, entry_target_offset);
      check_field("entry_symbol_segment", 32'(want.symbol_segment), 32'(entry_symbol_segment));
      check_field("entry_symbol_offset", want.symbol_offset, entry_symbol_offset);
      check_field("entry_code", 32'(want.code), 32'(entry_code));
      check_field("entry_owner", 32'(want.owner), 32'(entry_owner));
      check_field("status", 32'(want.status), 32'(status));
      check_field("last", 32'(want.last), 32'(last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) expand_record(cur_rec);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_rec = pending_q.pop_front();
          start_of_list <= cur_rec.start;
          action <= cur_rec.action;
          seg_target <= cur_rec.seg_target;
          seg_symbol <= cur_rec.seg_symbol;
          code_one <= cur_rec.code_one;
          code_two <= cur_rec.code_two;
          is_thumb <= cur_rec.is_thumb;
          target_offset <= cur_rec.target_offset;
          target_offset_two <= cur_rec.target_offset_two;
          symbol_offset <= cur_rec.symbol_offset;
          append_offset_one <= cur_rec.append_one;
          append_offset_two <= cur_rec.append_two;
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) check_beat();
      if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("** relocation_record_expander_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    record_t r;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // records ahead of any start run on the reset values
    r = rand_record(1'b0, ActRel);
    r.target_offset = 32'hFFFF_FFFF;
    pending_q.push_back(r);
    r = rand_record(1'b1, ActAbs);
    r.target_offset = 32'hFFFF_FFFF;
    r.append_one = 12'hFFF;
    r.code_one = 8'hFF;
    r.code_two = CodeNone;
    r.seg_target = 4'hF;
    r.seg_symbol = 4'hF;
    r.symbol_offset = 32'hFFFF_FFFF;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActAbsSplit);
    r.target_offset = 32'hFFFF_FFFF;
    r.target_offset_two = 20'hF_FFFF;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActRel);
    r.target_offset = '0;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActMov);
    r.is_thumb = 1'b1;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActMov);
    r.is_thumb = 1'b0;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActPair);
    r.append_one = '0;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActQuad);
    r.target_offset_two = 20'hF_FFFF;
    r.append_two = 12'hFFF;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActAbs32);
    r.target_offset = 32'd1;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActAbs32);
    r.target_offset = '0;
    pending_q.push_back(r);
    pending_q.push_back(rand_record(1'b0, ActPair));
    r = '0;
    r.start = 1'b1;
    r.action = ActAbsSplit;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActPack7);
    r.target_offset = 32'hFFFF_FFFF;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActPack4);
    r.target_offset = 32'h0FFF_FFFF;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActPack2);
    r.target_offset = 32'h0FFF_FFFF;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActPack2);
    r.target_offset = 32'hF000_0000;
    pending_q.push_back(r);
    r = rand_record(1'b0, ActPack7);
    r.target_offset = '0;
    pending_q.push_back(r);
    pending_q.push_back(rand_record(1'b1, ActRel));
    pending_q.push_back(rand_record(1'b0, ActAbs));
    pending_q.push_back(rand_record(1'b1, ActUnknownHi));
    pending_q.push_back(rand_record(1'b1, ActAbs));
    pending_q.push_back(rand_record(1'b0, ActUnknownLo));
    pending_q.push_back(rand_record(1'b1, ActAbsSplit));
    pending_q.push_back(rand_record(1'b0, ActUnknownHi));
    wait_drained();

    apb_write(RegOwnerSegment, {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'hF});
    load_lists(72);
    wait_drained();

    apb_write(RegOwnerSegment, 32'h0);
    load_lists(72);
    wait_drained();

    apb_write(RegOwnerSegment, $urandom);
    load_lists(72);
    wait_drained();

    apb_write(RegOwnerSegment, 32'h0000_000F);
    idle_on = 1'b0;
    load_lists(66);
    wait_drained();

    if (mismatches == 0) begin
      $display("** relocation_record_expander_unit: PASSED **");
    end else begin
      $display("** relocation_record_expander_unit: FAILED **");
    end
    $finish;
  end

endmodule
